### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dht_pkg.sv
// Shared types and constants for the double hashing insert block.
// No dependencies; used by every module of the block.
package dht_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
  localparam int SIZE_BITS   = SLOT_BITS + 1;
  localparam int KEY_BITS    = 16;
  localparam int COUNT_BITS  = 9;
  localparam int COUNT_MAX   = 511;

  localparam int HASH_SHIFT  = 8;
  localparam int HASH_SCALE  = 100;
  localparam int HASH_MUL    = (1 << HASH_SHIFT) * HASH_SCALE;

  // Divider geometry; dividend widths follow from the 16-bit key.
  localparam int DIV_BITS     = 32;
  localparam int DIV_CNT_BITS = 6;
  localparam int HASH_A_BITS  = 31;  // key * 25600
  localparam int MOD_BITS     = 7;   // the constant 100
  localparam int STEP_B_BITS  = 23;  // (key + 100) * 100 at most

  localparam int OUT_BYTES_BITS = 24;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAUNCH,
    S_HASH_Q,
    S_HASH_R,
    S_STEP_M,
    S_STEP_Q,
    S_STEP_R,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [SLOT_BITS-1:0] addr;
    logic [KEY_BITS-1:0]  key;
  } tbl_req_t;

  typedef struct packed {
    logic                used;
    logic [KEY_BITS-1:0] key;
  } tbl_rsp_t;

endpackage

### rtl/core/double_hash_table_insert_top.sv
// Double hashing insert: one key in, one status/slot/count result out.
// Each item runs five serial divisions on the shared 1-bit-per-cycle divider,
// then P probes (1..table size), each a memory read and a check.
// One item is in work at a time: the next is taken once this result is loaded
// into the output register, later while an earlier result waits. Reset: size
// 256, all slots empty, count zero.
module double_hash_table_insert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] item_key
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] insert_status, [9:2] slot_index,
                                 // [18:10] stored_count, [23:19] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // configured slot count
);

  localparam int SB = dht_pkg::SIZE_BITS;
  localparam int LB = dht_pkg::SLOT_BITS;
  localparam int KB = dht_pkg::KEY_BITS;
  localparam int CB = dht_pkg::COUNT_BITS;
  localparam int DB = dht_pkg::DIV_BITS;
  localparam int NB = dht_pkg::DIV_CNT_BITS;

  dht_pkg::state_t  state, state_next;
  dht_pkg::status_t res_status;
  dht_pkg::tbl_req_t req;
  dht_pkg::tbl_rsp_t rsp;

  logic [SB-1:0] size_cfg;
  logic [SB-1:0] size_eff;
  logic [SB-1:0] size_reg;
  logic [KB-1:0] key_reg;
  logic [LB-1:0] slot;
  logic [LB-1:0] step;
  logic [SB-1:0] probe_n;
  logic [LB-1:0] res_slot;
  logic [CB-1:0] entry_count;

  logic          div_start;
  logic [DB-1:0] div_dividend;
  logic [NB-1:0] div_nbits;
  logic          div_done;
  logic [DB-1:0] div_quot;
  logic [SB-1:0] div_rem;

  logic [SB-1:0] slot_sum;
  logic [LB-1:0] slot_adv;
  logic [SB-1:0] probe_n_inc;
  logic          out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SB'(dht_pkg::TABLE_DEPTH);
    end else if (cfg_valid) begin
      size_cfg <= cfg_data;
    end
  end

  always_comb begin
    size_eff = size_cfg;
    if (size_cfg == '0) begin
      size_eff = SB'(1);
    end else if (size_cfg > SB'(dht_pkg::TABLE_DEPTH)) begin
      size_eff = SB'(dht_pkg::TABLE_DEPTH);
    end
  end

  dht_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (size_reg),
    .nbits     (div_nbits),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  dht_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Next probe slot: both terms below size, so one subtract wraps it.
  assign slot_sum    = {1'b0, slot} + {1'b0, step};
  assign slot_adv    = (slot_sum >= size_reg) ? LB'(slot_sum - size_reg) : LB'(slot_sum);
  assign probe_n_inc = probe_n + 1'b1;
  assign out_load    = (state == dht_pkg::S_RESULT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_nbits    = '0;
    req          = '0;
    req.addr     = slot;
    req.key      = key_reg;
    case (state)
      dht_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = dht_pkg::S_LAUNCH;
        end
      end
      dht_pkg::S_LAUNCH: begin
        div_start    = 1'b1;
        div_dividend = DB'(key_reg) * DB'(dht_pkg::HASH_MUL);
        div_nbits    = NB'(dht_pkg::HASH_A_BITS);
        state_next   = dht_pkg::S_HASH_Q;
      end
      dht_pkg::S_HASH_Q: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quot;
          div_nbits    = NB'(dht_pkg::HASH_A_BITS);
          state_next   = dht_pkg::S_HASH_R;
        end
      end
      dht_pkg::S_HASH_R: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DB'(dht_pkg::HASH_SCALE);
          div_nbits    = NB'(dht_pkg::MOD_BITS);
          state_next   = dht_pkg::S_STEP_M;
        end
      end
      dht_pkg::S_STEP_M: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = (DB'(key_reg) + DB'(div_rem)) * DB'(dht_pkg::HASH_SCALE);
          div_nbits    = NB'(dht_pkg::STEP_B_BITS);
          state_next   = dht_pkg::S_STEP_Q;
        end
      end
      dht_pkg::S_STEP_Q: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quot;
          div_nbits    = NB'(dht_pkg::STEP_B_BITS);
          state_next   = dht_pkg::S_STEP_R;
        end
      end
      dht_pkg::S_STEP_R: begin
        if (div_done) begin
          state_next = dht_pkg::S_PROBE_RD;
        end
      end
      dht_pkg::S_PROBE_RD: begin
        req.rd     = 1'b1;
        state_next = dht_pkg::S_PROBE_CHK;
      end
      dht_pkg::S_PROBE_CHK: begin
        if (!rsp.used) begin
          req.wr     = 1'b1;
          state_next = dht_pkg::S_RESULT;
        end else if (rsp.key == key_reg) begin
          state_next = dht_pkg::S_RESULT;
        end else if (probe_n_inc == size_reg) begin
          state_next = dht_pkg::S_RESULT;
        end else begin
          state_next = dht_pkg::S_PROBE_RD;
        end
      end
      dht_pkg::S_RESULT: begin
        if (out_load) begin
          state_next = dht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dht_pkg::S_IDLE;
      end
    endcase
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (state == dht_pkg::S_IDLE && s_tvalid) begin
      key_reg  <= s_tdata[KB-1:0];
      size_reg <= size_eff;
    end
    if (state == dht_pkg::S_HASH_R && div_done) begin
      slot <= LB'(div_rem);
    end
    if (state == dht_pkg::S_STEP_R && div_done) begin
      step    <= LB'(div_rem);
      probe_n <= '0;
    end
    if (state == dht_pkg::S_PROBE_CHK) begin
      probe_n <= probe_n_inc;
      if (!rsp.used) begin
        res_status <= dht_pkg::ST_INSERTED;
        res_slot   <= slot;
      end else if (rsp.key == key_reg) begin
        res_status <= dht_pkg::ST_DUPLICATE;
        res_slot   <= slot;
      end else if (probe_n_inc == size_reg) begin
        res_status <= dht_pkg::ST_FULL;
        res_slot   <= '0;
      end else begin
        slot <= slot_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (state == dht_pkg::S_PROBE_CHK && !rsp.used &&
                 entry_count != CB'(dht_pkg::COUNT_MAX)) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= dht_pkg::OUT_BYTES_BITS'({entry_count, res_slot, res_status});
    end
  end

endmodule

### rtl/core/dht_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dht_pkg for widths.
module dht_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dht_pkg::DIV_BITS-1:0]      dividend,
  input  logic [dht_pkg::SIZE_BITS-1:0]     divisor,
  input  logic [dht_pkg::DIV_CNT_BITS-1:0]  nbits,
  output logic                              done,
  output logic [dht_pkg::DIV_BITS-1:0]      quotient,
  output logic [dht_pkg::SIZE_BITS-1:0]     remainder
);

  logic [dht_pkg::DIV_BITS-1:0]     dvd;
  logic [dht_pkg::SIZE_BITS-1:0]    rem;
  logic [dht_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                             busy;
  logic [dht_pkg::SIZE_BITS:0]      partial;
  logic [dht_pkg::SIZE_BITS:0]      diff;
  logic                             ge;

  assign partial = {rem, dvd[dht_pkg::DIV_BITS-1]};
  assign ge      = partial >= {1'b0, divisor};
  assign diff    = partial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == dht_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Left-align the dividend so only its significant bits are walked.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend << (dht_pkg::DIV_CNT_BITS'(dht_pkg::DIV_BITS) - nbits);
    end else if (busy) begin
      rem <= ge ? diff[dht_pkg::SIZE_BITS-1:0] : partial[dht_pkg::SIZE_BITS-1:0];
      dvd <= {dvd[dht_pkg::DIV_BITS-2:0], ge};
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

### rtl/core/dht_table.sv
// Slot store: key memory with a registered read, plus used flags.
// Depends on dht_pkg for request and response types.
module dht_table (
  input  logic              clk,
  input  logic              rst,
  input  dht_pkg::tbl_req_t req,
  output dht_pkg::tbl_rsp_t rsp
);

  logic [dht_pkg::KEY_BITS-1:0]    key_mem [dht_pkg::TABLE_DEPTH];
  logic [dht_pkg::TABLE_DEPTH-1:0] used;

  // Used flags clear at reset; a slot that was never written reads as empty.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      key_mem[req.addr] <= req.key;
    end
    if (req.rd) begin
      rsp.key <= key_mem[req.addr];
    end
    if (rst) begin
      used     <= '0;
      rsp.used <= 1'b0;
    end else begin
      if (req.wr) begin
        used[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        rsp.used <= used[req.addr];
      end
    end
  end

endmodule

### rtl/core/dht_checker.sv
// Port-level checks for the double hashing insert top level.
// Depends on dht_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module dht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  `CHK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CHK_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
  `CHK_ASSERT(a_full_slot_zero, m_tvalid && m_tdata[1:0] == dht_pkg::ST_FULL |-> m_tdata[9:2] == 8'd0, "full result with nonzero slot")
  `CHK_ASSERT(a_count_bound, m_tvalid |-> m_tdata[18:10] <= 9'(dht_pkg::TABLE_DEPTH), "stored count above table depth")
  `CHK_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid right after reset")

endmodule

bind double_hash_table_insert_top dht_checker u_dht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for double_hash_table_insert_top: streams keys, predicts
// each insert outcome with its own copy of the probe table, and checks every result.
// Depends on dht_pkg and the block's RTL only.
module testbench;

  typedef struct packed {
    dht_pkg::status_t status;
    logic [7:0]       slot;
    logic [8:0]       count;
  } insert_outcome_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;     // [15:0] item_key
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;     // [1:0] insert_status, [9:2] slot_index, [18:10] stored_count
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;    // configured slot count

  // shadow of the probe table
  logic [15:0] shadow_keys [dht_pkg::TABLE_DEPTH];
  bit          shadow_used [dht_pkg::TABLE_DEPTH];
  int unsigned shadow_count;
  logic [8:0]  shadow_size;

  insert_outcome_t outcomes[$];
  logic [15:0]     sent_keys[$];
  int errors;
  int n_inserted, n_duplicate, n_full, n_resizes;
  bit src_gaps, sink_gaps;
  int hold_len;

  double_hash_table_insert_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  // Walk the probe sequence and apply the insert to the shadow table.
  function automatic insert_outcome_t probe_insert(input logic [15:0] key);
    longint unsigned sz, pos, stride, k;
    insert_outcome_t r;
    sz = 64'(shadow_size);
    if (sz == 0) sz = 1;
    if (sz > dht_pkg::TABLE_DEPTH) sz = dht_pkg::TABLE_DEPTH;
    k = 64'(key);
    pos    = ((k << dht_pkg::HASH_SHIFT) * dht_pkg::HASH_SCALE / sz) % sz;
    stride = ((k + (dht_pkg::HASH_SCALE % sz)) * dht_pkg::HASH_SCALE / sz) % sz;
    r.status = dht_pkg::ST_FULL;
    r.slot   = '0;
    for (longint unsigned n = 0; n < sz; n++) begin
      if (!shadow_used[pos]) begin
        shadow_used[pos] = 1'b1;
        shadow_keys[pos] = key;
        if (shadow_count < dht_pkg::COUNT_MAX) shadow_count++;
        r.status = dht_pkg::ST_INSERTED;
        r.slot   = pos[7:0];
        break;
      end
      if (shadow_keys[pos] == key) begin
        r.status = dht_pkg::ST_DUPLICATE;
        r.slot   = pos[7:0];
        break;
      end
      pos = (pos + stride) % sz;
    end
    r.count = shadow_count[8:0];
    return r;
  endfunction

  task automatic send_key(input logic [15:0] key);
    int gap;
    gap = (src_gaps && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    outcomes.push_back(probe_insert(key));
    sent_keys.push_back(key);
  endtask

  // Hold the input side until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic resize_table(input logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_size = value;
    n_resizes++;
  endtask

  task automatic test_reset_state();
    send_key(16'h0000);
    send_key(16'hFFFF);
    send_key(16'h0000);
    send_key(16'h0001);
    send_key(16'hA5A5);
  endtask

  task automatic test_size_clamp();
    // zero acts as one slot
    resize_table(9'd0);
    send_key(16'h0000);
    send_key(16'h1234);
    // above the depth acts as the full depth
    resize_table(9'h1FF);
    send_key(16'h5A5A);
    send_key(16'h5A5A);
    resize_table(9'd257);
    send_key(16'h8000);
  endtask

  task automatic test_zero_step();
    // two slots: every key starts at slot 0 with a zero stride
    resize_table(9'd2);
    send_key(16'h0042);
    send_key(16'h0000);
  endtask

  task automatic test_small_fill();
    resize_table(9'd5);
    for (int k = 10; k < 17; k++) send_key(k[15:0]);
    // shrink and grow over occupied slots
    resize_table(9'd3);
    send_key(16'd10);
    send_key(16'd40);
    resize_table(9'd8);
    send_key(16'd41);
    send_key(16'd42);
  endtask

  task automatic test_output_hold();
    resize_table(9'd256);
    src_gaps = 1'b0;
    hold_len = 400;
    repeat (8) send_key(16'($urandom_range(0, 16'hFFFF)));
    src_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (10) send_key(16'($urandom_range(0, 16'hFFFF)));
    drain();
    repeat (10) send_key(16'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic test_random_phases();
    logic [8:0]  size_pick;
    logic [15:0] key;
    int bitpos, count;
    for (int p = 0; p < 14; p++) begin
      case ($urandom_range(0, 9))
        0:       size_pick = 9'($urandom_range(0, 2));
        1:       size_pick = 9'd256;
        2:       size_pick = 9'($urandom_range(257, 511));
        3, 4, 5: size_pick = 9'($urandom_range(3, 32));
        default: size_pick = 9'($urandom_range(33, 255));
      endcase
      resize_table(size_pick);
      src_gaps  = (p % 4 != 1) && (p % 4 != 3);
      sink_gaps = (p % 4 != 2) && (p % 4 != 3);
      count = $urandom_range(80, 120);
      for (int i = 0; i < count; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
          4: begin
            bitpos = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
              0:       key = 16'h0000;
              1:       key = 16'hFFFF;
              2:       key = 16'h1 << bitpos;
              default: key = ~(16'h1 << bitpos);
            endcase
          end
          default: key = 16'($urandom_range(0, 16'hFFFF));
        endcase
        send_key(key);
      end
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // result side: random stalls, plus a long hold when one is requested
  initial begin : result_sink
    int len;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        len = hold_len;
        hold_len = 0;
        m_tready <= 1'b0;
        for (int n = 0; n < len; n++) @(posedge clk);
      end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    insert_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      case (m_tdata[1:0])
        dht_pkg::ST_INSERTED:  n_inserted++;
        dht_pkg::ST_DUPLICATE: n_duplicate++;
        default:               n_full++;
      endcase
      if (outcomes.size() == 0) begin
        $error("result with no item pending: m_tdata %h", m_tdata);
        errors++;
      end else begin
        want = outcomes.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("insert_status: expected %0d, got %0d", want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[9:2] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, m_tdata[9:2]);
          errors++;
        end
        if (m_tdata[18:10] !== want.count) begin
          $error("stored_count: expected %0d, got %0d", want.count, m_tdata[18:10]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    hold_len  = 0;
    errors    = 0;
    n_inserted = 0;
    n_duplicate = 0;
    n_full    = 0;
    n_resizes = 0;
    for (int i = 0; i < dht_pkg::TABLE_DEPTH; i++) begin
      shadow_used[i] = 1'b0;
      shadow_keys[i] = '0;
    end
    shadow_count = 0;
    shadow_size  = 9'd256;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_size_clamp();
    test_zero_step();
    test_small_fill();
    test_output_hold();
    test_sender_pause();
    test_random_phases();

    drain();
    repeat (700) @(posedge clk);
    $display("covered %0d keys over %0d table size writes", sent_keys.size(), n_resizes);
    $display("outcomes: %0d inserted, %0d duplicate, %0d full, %0d stored at end",
             n_inserted, n_duplicate, n_full, shadow_count);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dht_pkg.sv
rtl/core/dht_divider.sv
rtl/core/dht_table.sv
rtl/core/double_hash_table_insert_top.sv
rtl/core/dht_checker.sv
tb/sv/testbench.sv
